// ===== sv/vrd_pkg.sv =====
package vrd_pkg;

  // result kinds
  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;
  localparam logic [1:0] KIND_UNEXP = 2'd3;

  // request commands
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_ANSWER = 1'b1;

  // configuration
  localparam logic       REG_MAX_REACH = 1'b0;
  localparam logic [15:0] MAX_REACH_RST = 16'd2048;

  // controller to datapath
  typedef struct packed {
    logic       take_start;
    logic       ld_unexp;
    logic       ld_hit;
    logic       ld_miss;
    logic       step_init;
    logic       sq_acc;
    logic       root_init;
    logic       root_step;
    logic       nrm_ld;
    logic       nrm_store;
    logic       num_calc;
    logic       step_ld;
    logic       step_cmp;
    logic       step_fin;
    logic       start_fin;
    logic       emit;
    logic [1:0] axis;
  } vrd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic sq_zero;
    logic root_done;
    logic div_busy;
    logic nrm_sat;
    logic step_skip;
    logic step_direct;
    logic out_free;
  } vrd_sts_t;

endpackage

// ===== sv/vrd_if.sv =====
interface vrd_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic               cell_is_target;

  modport source (output valid, command, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, cell_is_target, input ready);
  modport sink (input valid, command, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, cell_is_target, output ready);
endinterface

interface vrd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [19:0] cell_x;
  logic signed [19:0] cell_y;
  logic signed [19:0] cell_z;
  logic signed [1:0]  normal_x;
  logic signed [1:0]  normal_y;
  logic signed [1:0]  normal_z;
  logic [15:0]        hit_distance;

  modport source (output valid, kind, cell_x, cell_y, cell_z, normal_x, normal_y,
                  normal_z, hit_distance, input ready);
  modport sink (input valid, kind, cell_x, cell_y, cell_z, normal_x, normal_y,
                normal_z, hit_distance, output ready);
endinterface

// ===== sv/voxel_ray_dda_stepper.sv =====
// channel  | dir | handshake       | carries
// in_i     | in  | valid / ready   | start request or answer for the asked cell
// out_o    | out | valid / ready   | query, hit, miss or unexpected-answer result
// apb      | in  | psel / penable  | max_reach register at byte address 0
//
// start request: square each axis, check for a zero length, square root, normalize each axis, finish
// answer without target: boundary offset and divide for each axis in turn, then finish
// hit or unexpected answer: goes straight to the result; a zero axis, or a boundary behind or far, skips its divide
// reset clears control state and loads max_reach with 8.0; no clearing pass
// a stalled result holds in the output register while the next request is taken
module voxel_ray_dda_stepper #(
  parameter int CELL_COORD_BITS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vrd_in_if.sink       in_i,
  vrd_out_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // configuration register, written on the access phase
  logic [15:0] max_reach_q;
  logic        cfg_wr;
  logic        sel_reach;

  assign pready    = 1'b1;
  assign sel_reach = paddr[2] == vrd_pkg::REG_MAX_REACH;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = sel_reach ? {16'b0, max_reach_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_reach_q <= vrd_pkg::MAX_REACH_RST;
    end else if (cfg_wr && sel_reach) begin
      max_reach_q <= pwdata[15:0];
    end
  end

  // controller / datapath link
  vrd_pkg::vrd_cmd_t cmd;
  vrd_pkg::vrd_sts_t sts;

  logic signed [31:0] origin [3];
  logic signed [15:0] dir [3];
  logic signed [19:0] out_cell [3];
  logic signed [1:0]  normal [3];

  assign origin[0] = in_i.origin_x;
  assign origin[1] = in_i.origin_y;
  assign origin[2] = in_i.origin_z;
  assign dir[0]    = in_i.dir_x;
  assign dir[1]    = in_i.dir_y;
  assign dir[2]    = in_i.dir_z;

  // sequencer: one request at a time, state walk per request type
  vrd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_target_i  (in_i.cell_is_target),
    .in_ready_o   (in_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // ray state, square root, shared divider and output register
  vrd_dp #(
    .CELL_COORD_BITS (CELL_COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .max_reach_i  (max_reach_q),
    .in_origin_i  (origin),
    .in_dir_i     (dir),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_kind_o   (out_o.kind),
    .out_cell_o   (out_cell),
    .out_normal_o (normal),
    .out_dist_o   (out_o.hit_distance)
  );

  assign out_o.cell_x   = out_cell[0];
  assign out_o.cell_y   = out_cell[1];
  assign out_o.cell_z   = out_cell[2];
  assign out_o.normal_x = normal[0];
  assign out_o.normal_y = normal[1];
  assign out_o.normal_z = normal[2];

endmodule

// ===== sv/vrd_div.sv =====
module vrd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        busy_o,
  output logic [15:0] quo_o
);

  // restoring divide, one quotient bit per cycle; num_i[31:16] < den_i
  logic [15:0] rem_q, rem_d;
  logic [15:0] sh_q, sh_d;
  logic [15:0] den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] part;
  logic [16:0] trial;
  logic        take;

  assign part  = {rem_q, sh_q[15]};
  assign take  = part >= {1'b0, den_q};
  assign trial = part - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_i[31:16];
      sh_d   = num_i[15:0];
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = take ? trial[15:0] : part[15:0];
      sh_d   = {sh_q[14:0], take};
      cnt_d  = cnt_q - 5'd1;
      busy_d = cnt_q != 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = sh_q;

endmodule

// ===== sv/vrd_ctrl.sv =====
module vrd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_command_i,
  input  logic               in_target_i,
  output logic               in_ready_o,
  input  vrd_pkg::vrd_sts_t  sts_i,
  output vrd_pkg::vrd_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_NLD  = 4'd4;
  localparam logic [3:0] S_NRUN = 4'd5;
  localparam logic [3:0] S_SFIN = 4'd6;
  localparam logic [3:0] S_NUM  = 4'd7;
  localparam logic [3:0] S_SLD  = 4'd8;
  localparam logic [3:0] S_SRUN = 4'd9;
  localparam logic [3:0] S_TFIN = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0] st_q, st_d;
  logic [1:0] ax_q, ax_d;
  logic       last_ax;

  assign last_ax    = ax_q == 2'd2;
  assign in_ready_o = st_q == S_IDLE;

  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = ax_q;
    st_d       = st_q;
    ax_d       = ax_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ax_d = 2'd0;
          if (in_command_i == vrd_pkg::CMD_START) begin
            cmd_o.take_start = 1'b1;
            st_d             = S_SQ;
          end else if (!sts_i.busy) begin
            cmd_o.ld_unexp = 1'b1;
            st_d           = S_EMIT;
          end else if (in_target_i) begin
            cmd_o.ld_hit = 1'b1;
            st_d         = S_EMIT;
          end else begin
            cmd_o.step_init = 1'b1;
            st_d            = S_NUM;
          end
        end
      end
      S_SQ: begin
        cmd_o.sq_acc = 1'b1;
        if (last_ax) begin
          st_d = S_CHK;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_CHK: begin
        if (sts_i.sq_zero) begin
          cmd_o.ld_miss = 1'b1;
          st_d          = S_EMIT;
        end else begin
          cmd_o.root_init = 1'b1;
          st_d            = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts_i.root_done) begin
          ax_d = 2'd0;
          st_d = S_NLD;
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      S_NLD: begin
        cmd_o.nrm_ld = 1'b1;
        if (!sts_i.nrm_sat) begin
          st_d = S_NRUN;
        end else if (last_ax) begin
          st_d = S_SFIN;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_NRUN: begin
        if (!sts_i.div_busy) begin
          cmd_o.nrm_store = 1'b1;
          if (last_ax) begin
            st_d = S_SFIN;
          end else begin
            ax_d = ax_q + 2'd1;
            st_d = S_NLD;
          end
        end
      end
      S_SFIN: begin
        cmd_o.start_fin = 1'b1;
        st_d            = S_EMIT;
      end
      S_NUM: begin
        cmd_o.num_calc = 1'b1;
        st_d           = S_SLD;
      end
      S_SLD: begin
        cmd_o.step_ld = 1'b1;
        if (!(sts_i.step_skip || sts_i.step_direct)) begin
          st_d = S_SRUN;
        end else if (last_ax) begin
          st_d = S_TFIN;
        end else begin
          ax_d = ax_q + 2'd1;
          st_d = S_NUM;
        end
      end
      S_SRUN: begin
        if (!sts_i.div_busy) begin
          cmd_o.step_cmp = 1'b1;
          if (last_ax) begin
            st_d = S_TFIN;
          end else begin
            ax_d = ax_q + 2'd1;
            st_d = S_NUM;
          end
        end
      end
      S_TFIN: begin
        cmd_o.step_fin = 1'b1;
        st_d           = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          st_d       = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ax_q <= 2'd0;
    end else begin
      st_q <= st_d;
      ax_q <= ax_d;
    end
  end

endmodule

// ===== sv/vrd_dp.sv =====
module vrd_dp #(
  parameter int CELL_COORD_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrd_pkg::vrd_cmd_t  cmd_i,
  output vrd_pkg::vrd_sts_t  sts_o,
  input  logic [15:0]        max_reach_i,
  input  logic signed [31:0] in_origin_i [3],
  input  logic signed [15:0] in_dir_i [3],
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         out_kind_o,
  output logic signed [19:0] out_cell_o [3],
  output logic signed [1:0]  out_normal_o [3],
  output logic [15:0]        out_dist_o
);

  localparam int CB = CELL_COORD_BITS;
  localparam int SW = (CB + 12 > 33) ? CB + 12 : 33;
  localparam int NW = ((CB + 12 > 32) ? CB + 12 : 32) + 2;

  logic signed [31:0]   org_q [3];
  logic signed [15:0]   dir_q [3];
  logic signed [15:0]   unit_q [3];
  logic signed [CB-1:0] cur_q [3];
  logic signed [CB-1:0] ask_q [3];
  logic [15:0]          adist_q;
  logic                 busy_q;
  logic                 at_start_q;
  logic [1:0]           kind_q;
  logic [31:0]          acc_q;
  logic [31:0]          x_q, r_q, bit_q;
  logic [15:0]          best_q;
  logic [1:0]           bax_q;
  logic                 found_q;
  logic [NW-1:0]        nabs_q;
  logic                 nneg_q;
  logic                 nzero_q;
  logic                 out_valid_q;

  logic [1:0]           ax;
  assign ax = cmd_i.axis;

  // squares of the direction, one axis a cycle
  logic signed [31:0] sq;
  assign sq = dir_q[ax] * dir_q[ax];

  // bit-pair square root step
  logic [32:0] rb;
  logic        rtake;
  assign rb    = {1'b0, r_q} + {1'b0, bit_q};
  assign rtake = {1'b0, x_q} >= rb;

  logic [15:0] len;
  assign len = r_q[15:0];

  // direction normalize
  logic signed [15:0] d_sel;
  logic [15:0]        dmag;
  logic               nsat;
  assign d_sel = dir_q[ax];
  assign dmag  = d_sel[15] ? (~$unsigned(d_sel) + 16'd1) : $unsigned(d_sel);
  assign nsat  = dmag >= len;

  // boundary offset for a step
  logic signed [15:0]   u_sel;
  logic [15:0]          umag;
  logic signed [NW-1:0] cw, ow, half, num;
  assign u_sel = unit_q[ax];
  assign umag  = u_sel[15] ? (~$unsigned(u_sel) + 16'd1) : $unsigned(u_sel);
  assign cw    = NW'(cur_q[ax]);
  assign ow    = NW'(org_q[ax]);
  assign half  = u_sel[15] ? -NW'(2048) : NW'(2048);
  assign num   = (cw <<< 12) + half - ow;

  logic        skip, tzero, direct;
  logic [15:0] direct_t;
  assign skip     = u_sel == '0;
  assign tzero    = nzero_q || (nneg_q ^ u_sel[15]);
  assign direct   = tzero || (nabs_q >= NW'({umag, 5'b0}));
  assign direct_t = tzero ? 16'd0 : 16'hFFFF;

  // shared divider
  logic        div_start;
  logic [31:0] div_num;
  logic [15:0] div_den;
  logic        div_busy;
  logic [15:0] div_quo;

  assign div_start = (cmd_i.nrm_ld && !nsat) || (cmd_i.step_ld && !skip && !direct);
  assign div_num   = cmd_i.nrm_ld ? {1'b0, dmag, 15'b0} : {nabs_q[20:0], 11'b0};
  assign div_den   = cmd_i.nrm_ld ? len : umag;

  vrd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // candidate distance for the compare
  logic [15:0] cand;
  logic        cand_ok;
  assign cand    = cmd_i.step_cmp ? div_quo : direct_t;
  assign cand_ok = cmd_i.step_cmp || (cmd_i.step_ld && !skip && direct);

  // start cell from origin
  logic signed [SW-1:0] scell [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scell[i] = SW'(org_q[i]) + SW'(2048);
    end
  end

  // stepped cell
  logic signed [CB-1:0] step_cell;
  assign step_cell = unit_q[bax_q][15] ? cur_q[bax_q] - CB'(1) : cur_q[bax_q] + CB'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      at_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= vrd_pkg::KIND_QUERY;
    end else begin
      if (cmd_i.ld_hit || cmd_i.ld_miss) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.start_fin) begin
        busy_q     <= 1'b1;
        at_start_q <= 1'b1;
      end
      if (cmd_i.step_init) begin
        at_start_q <= 1'b0;
      end
      if (cmd_i.step_fin && !found_q) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.ld_unexp) begin
        kind_q <= vrd_pkg::KIND_UNEXP;
      end else if (cmd_i.ld_hit) begin
        kind_q <= vrd_pkg::KIND_HIT;
      end else if (cmd_i.ld_miss || (cmd_i.step_fin && !found_q)) begin
        kind_q <= vrd_pkg::KIND_MISS;
      end else if (cmd_i.start_fin || cmd_i.step_fin) begin
        kind_q <= vrd_pkg::KIND_QUERY;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_start) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= in_origin_i[i];
        dir_q[i] <= in_dir_i[i];
      end
      acc_q <= '0;
    end
    if (cmd_i.sq_acc) begin
      acc_q <= acc_q + $unsigned(sq);
    end
    if (cmd_i.root_init) begin
      x_q   <= acc_q;
      r_q   <= '0;
      bit_q <= 32'h4000_0000;
    end else if (cmd_i.root_step) begin
      if (rtake) begin
        x_q <= x_q - rb[31:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.nrm_ld && nsat) begin
      unit_q[ax] <= d_sel[15] ? 16'sh8000 : 16'sh7FFF;
    end
    if (cmd_i.nrm_store) begin
      unit_q[ax] <= d_sel[15] ? $signed(~div_quo + 16'd1) : $signed(div_quo);
    end
    if (cmd_i.start_fin) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= scell[i][12 +: CB];
        ask_q[i] <= scell[i][12 +: CB];
      end
      adist_q <= '0;
    end
    if (cmd_i.step_init) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= ask_q[i];
      end
      best_q  <= max_reach_i;
      found_q <= 1'b0;
      bax_q   <= 2'd0;
    end
    if (cmd_i.num_calc) begin
      nneg_q  <= num[NW-1];
      nzero_q <= num == '0;
      nabs_q  <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
    end
    if (cand_ok && (cand < best_q)) begin
      best_q  <= cand;
      bax_q   <= ax;
      found_q <= 1'b1;
    end
    if (cmd_i.step_fin && found_q) begin
      ask_q[bax_q] <= step_cell;
      adist_q      <= best_q;
    end
  end

  // result fields, built when the result register loads
  logic signed [CB-1:0] diff [3];
  logic signed [1:0]    nrm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = cur_q[i] - ask_q[i];
      if (at_start_q) begin
        if (unit_q[i] > 16'sd0) begin
          nrm[i] = -2'sd1;
        end else if (unit_q[i] < 16'sd0) begin
          nrm[i] = 2'sd1;
        end else begin
          nrm[i] = 2'sd0;
        end
      end else if (diff[i] > CB'(1)) begin
        nrm[i] = -2'sd1;
      end else if (diff[i] < -CB'(1)) begin
        nrm[i] = 2'sd1;
      end else begin
        nrm[i] = diff[i][1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o <= kind_q;
      out_dist_o <= '0;
      for (int i = 0; i < 3; i++) begin
        out_cell_o[i]   <= '0;
        out_normal_o[i] <= '0;
      end
      case (kind_q)
        vrd_pkg::KIND_QUERY: begin
          for (int i = 0; i < 3; i++) begin
            out_cell_o[i] <= 20'(ask_q[i]);
          end
        end
        vrd_pkg::KIND_HIT: begin
          for (int i = 0; i < 3; i++) begin
            out_cell_o[i]   <= 20'(ask_q[i]);
            out_normal_o[i] <= nrm[i];
          end
          out_dist_o <= at_start_q ? 16'd0 : adist_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o             = '0;
    sts_o.busy        = busy_q;
    sts_o.sq_zero     = acc_q == '0;
    sts_o.root_done   = bit_q == '0;
    sts_o.div_busy    = div_busy;
    sts_o.nrm_sat     = nsat;
    sts_o.step_skip   = skip;
    sts_o.step_direct = direct;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

// ===== sv/vrd_checker.sv =====
module vrd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         kind_i,
  input logic signed [19:0] cell_x_i,
  input logic signed [19:0] cell_y_i,
  input logic signed [19:0] cell_z_i,
  input logic signed [1:0]  normal_x_i,
  input logic signed [1:0]  normal_y_i,
  input logic signed [1:0]  normal_z_i,
  input logic [15:0]        dist_i
);

  // a request is worked on alone
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after a request");

  // only a hit carries normal and distance
  a_hit_only_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != vrd_pkg::KIND_HIT |->
      normal_x_i == 2'sd0 && normal_y_i == 2'sd0 && normal_z_i == 2'sd0 &&
      dist_i == 16'd0)
    else $error("normal or distance on a non-hit result");

  // miss and unexpected answer carry no cell
  a_miss_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == vrd_pkg::KIND_MISS || kind_i == vrd_pkg::KIND_UNEXP) |->
      cell_x_i == 20'sd0 && cell_y_i == 20'sd0 && cell_z_i == 20'sd0)
    else $error("cell on a miss or unexpected result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(cell_x_i) && $stable(cell_y_i) && $stable(cell_z_i) && $stable(dist_i))
    else $error("stalled result changed");

endmodule

bind voxel_ray_dda_stepper vrd_checker u_vrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .cell_x_i    (out_o.cell_x),
  .cell_y_i    (out_o.cell_y),
  .cell_z_i    (out_o.cell_z),
  .normal_x_i  (out_o.normal_x),
  .normal_y_i  (out_o.normal_y),
  .normal_z_i  (out_o.normal_z),
  .dist_i      (out_o.hit_distance)
);

// ===== tb/tb_voxel_ray_dda_stepper.sv =====
`timescale 1ns / 100ps

module tb_voxel_ray_dda_stepper;

  localparam int CB = 20;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        command;
    logic [31:0] ox, oy, oz;
    logic [15:0] dx, dy, dz;
    logic        target;
  } ray_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] cx, cy, cz;
    logic [1:0]  nx, ny, nz;
    logic [15:0] hit_dist;
  } ray_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vrd_in_if  req_if ();
  vrd_out_if res_if ();

  voxel_ray_dda_stepper i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if.sink), .out_o(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state, mirrors the block
  logic [15:0] reach_q;
  logic        tracing;
  logic        first_cell;
  longint      org [3];
  longint      udir [3];
  longint      cur_cell [3];
  longint      ask_cell [3];
  longint      ask_dist;

  ray_req_t pending_reqs [$];
  ray_res_t expected_results [$];
  int       mismatches = 0;
  int       n_hits = 0, n_misses = 0, n_queries = 0, n_unexp = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       out_stall = 1'b0;
  bit       req_taken = 1'b0;

  function automatic longint wrap_cell(longint c);
    logic [CB-1:0] w;
    w = c[CB-1:0];
    return longint'($signed(w));
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic ray_res_t make_res(logic [1:0] k, bit with_cell, longint n[3], longint d);
    ray_res_t r;
    r = '0;
    r.kind = k;
    if (with_cell) begin
      r.cx = ask_cell[0][19:0];
      r.cy = ask_cell[1][19:0];
      r.cz = ask_cell[2][19:0];
    end
    r.nx = n[0][1:0];
    r.ny = n[1][1:0];
    r.nz = n[2][1:0];
    r.hit_dist = d[15:0];
    return r;
  endfunction

  // works out the result of one accepted request and updates the ray state
  function automatic ray_res_t trace_step(ray_req_t q);
    longint d [3];
    longint zn [3];
    longint nrm [3];
    longint len2, len, v, best, u, num, t;
    int axis;
    zn = '{0, 0, 0};
    if (q.command == vrd_pkg::CMD_START) begin
      org[0] = longint'($signed(q.ox));
      org[1] = longint'($signed(q.oy));
      org[2] = longint'($signed(q.oz));
      d[0] = longint'($signed(q.dx));
      d[1] = longint'($signed(q.dy));
      d[2] = longint'($signed(q.dz));
      len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      if (len2 == 0) begin
        tracing = 1'b0;
        return make_res(vrd_pkg::KIND_MISS, 0, zn, 0);
      end
      len = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
        v = (d[i] * 32768) / len;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        udir[i] = v;
        // floor((origin + half) / 4096)
        cur_cell[i] = wrap_cell((org[i] + 2048) >>> 12);
        ask_cell[i] = cur_cell[i];
      end
      ask_dist = 0;
      first_cell = 1'b1;
      tracing = 1'b1;
      return make_res(vrd_pkg::KIND_QUERY, 1, zn, 0);
    end
    if (!tracing) return make_res(vrd_pkg::KIND_UNEXP, 0, zn, 0);
    if (q.target) begin
      for (int i = 0; i < 3; i++) begin
        if (first_cell) nrm[i] = udir[i] > 0 ? -1 : (udir[i] < 0 ? 1 : 0);
        else nrm[i] = wrap_cell(cur_cell[i] - ask_cell[i]);
        if (nrm[i] > 1 || nrm[i] < -1) nrm[i] = -nrm[i] > 0 ? 1 : -1;
      end
      tracing = 1'b0;
      return make_res(vrd_pkg::KIND_HIT, 1, nrm, first_cell ? 0 : ask_dist);
    end
    best = longint'(reach_q);
    axis = -1;
    for (int i = 0; i < 3; i++) cur_cell[i] = ask_cell[i];
    first_cell = 1'b0;
    for (int i = 0; i < 3; i++) begin
      u = udir[i];
      if (u != 0) begin
        num = cur_cell[i] * 4096 + (u > 0 ? 2048 : -2048) - org[i];
        t = (num * 2048) / u;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        if (t < best) begin
          best = t;
          axis = i;
        end
      end
    end
    if (axis < 0) begin
      tracing = 1'b0;
      return make_res(vrd_pkg::KIND_MISS, 0, zn, 0);
    end
    ask_cell[axis] = wrap_cell(cur_cell[axis] + (udir[axis] > 0 ? 1 : -1));
    ask_dist = best;
    return make_res(vrd_pkg::KIND_QUERY, 1, zn, 0);
  endfunction

  // request driver: bursts with random gaps, changes at the falling edge
  int gap_left = 0, burst_left = 0;
  initial begin
    req_if.valid = 1'b0;
    req_if.command = vrd_pkg::CMD_START;
    req_if.origin_x = '0; req_if.origin_y = '0; req_if.origin_z = '0;
    req_if.dir_x = '0; req_if.dir_y = '0; req_if.dir_z = '0;
    req_if.cell_is_target = 1'b0;
    res_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // acceptance was seen at the last rising edge
      if (req_taken) begin
        void'(pending_reqs.pop_front());
      end
      // a request still waiting keeps valid high
      if (!req_if.valid || req_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          ray_req_t nx;
          nx = pending_reqs[0];
          req_if.valid <= 1'b1;
          {req_if.command, req_if.origin_x, req_if.origin_y, req_if.origin_z,
           req_if.dir_x, req_if.dir_y, req_if.dir_z, req_if.cell_is_target} <= nx;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      // result stall pattern: long open stretches, then stall runs
      res_if.ready <= out_stall ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 63) == 0) out_stall = ~out_stall;
    end
  end

  // monitor: predicts at request acceptance, checks at result acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (req_if.valid && req_if.ready) begin
        ray_req_t q;
        q = {req_if.command, req_if.origin_x, req_if.origin_y, req_if.origin_z,
             req_if.dir_x, req_if.dir_y, req_if.dir_z, req_if.cell_is_target};
        expected_results.push_back(trace_step(q));
        req_taken = 1'b1;
        idle_cycles = 0;
      end
      if (res_if.valid && res_if.ready) begin
        ray_res_t got, exp_r;
        got = {res_if.kind, res_if.cell_x, res_if.cell_y, res_if.cell_z,
               res_if.normal_x, res_if.normal_y, res_if.normal_z, res_if.hit_distance};
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          case (exp_r.kind)
            vrd_pkg::KIND_HIT:   n_hits++;
            vrd_pkg::KIND_MISS:  n_misses++;
            vrd_pkg::KIND_QUERY: n_queries++;
            default:             n_unexp++;
          endcase
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp kind %0d cell %h %h %h nrm %h %h %h dist %h,",
                        " got kind %0d cell %h %h %h nrm %h %h %h dist %h"},
                exp_r.kind, exp_r.cx, exp_r.cy, exp_r.cz, exp_r.nx, exp_r.ny, exp_r.nz,
                exp_r.hit_dist, got.kind, got.cx, got.cy, got.cz, got.nx, got.ny, got.nz,
                got.hit_dist);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic ray_req_t start_req(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
    ray_req_t q;
    q = {vrd_pkg::CMD_START, ox, oy, oz, dx, dy, dz, 1'b0};
    return q;
  endfunction

  function automatic ray_req_t answer_req(logic tgt);
    ray_req_t q;
    q = '0;
    q.command = vrd_pkg::CMD_ANSWER;
    q.target = tgt;
    // payload bits are don't-care for an answer, still toggle them
    q.ox = $urandom; q.oy = $urandom; q.oz = $urandom;
    q.dx = 16'($urandom); q.dy = 16'($urandom); q.dz = 16'($urandom);
    return q;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'($urandom_range(0, 3));
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_origin();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? 12'hfff : 12'h000, 20'($urandom)};
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed(32'($urandom_range(0, 65535))) - 32768;
    endcase
  endfunction

  task automatic apb_write(logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * vrd_pkg::REG_MAX_REACH); pwdata <= {16'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    reach_q = val;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // one ray: start, then a random number of answers without target, mostly closed by a target answer
  task automatic queue_ray(int max_steps);
    int steps;
    pending_reqs.push_back(start_req(rand_origin(), rand_origin(), rand_origin(),
                                     rand_dir(), rand_dir(), rand_dir()));
    steps = $urandom_range(0, max_steps);
    for (int i = 0; i < steps; i++) pending_reqs.push_back(answer_req(1'b0));
    if ($urandom_range(0, 3) != 0) pending_reqs.push_back(answer_req(1'b1));
  endtask

  logic [15:0] reach_set [5] = '{16'd0, 16'hffff, 16'd2048, 16'd256, 16'd1500};

  initial begin
    reach_q = vrd_pkg::MAX_REACH_RST;
    tracing = 1'b0;
    first_cell = 1'b0;
    ask_dist = 0;
    for (int i = 0; i < 3; i++) begin
      org[i] = 0; udir[i] = 0; cur_cell[i] = 0; ask_cell[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle answer, zero direction, axis rays, tiny component,
    // start cell hit, restart while busy, extreme origins with cell wrap
    pending_reqs.push_back(answer_req(1'b0));
    pending_reqs.push_back(start_req(0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(answer_req(1'b1));
    pending_reqs.push_back(start_req(32'h800, 0, 0, 16'h7fff, 0, 0));
    pending_reqs.push_back(answer_req(1'b1));
    pending_reqs.push_back(start_req(0, 32'h1234, 0, 16'h0001, 16'h8000, 0));
    pending_reqs.push_back(answer_req(1'b0));
    pending_reqs.push_back(answer_req(1'b0));
    pending_reqs.push_back(answer_req(1'b1));
    pending_reqs.push_back(start_req(32'h7fffffff, 32'h80000000, 32'hfffff800,
                                     16'h4000, 16'h4000, 16'h4000));
    pending_reqs.push_back(answer_req(1'b0));
    pending_reqs.push_back(start_req(32'h80000000, 32'h7ffff7ff, 0,
                                     16'h8000, 16'h7fff, 16'h8000));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(answer_req(1'b0));
    pending_reqs.push_back(answer_req(1'b1));
    pending_reqs.push_back(answer_req(1'b0));
    drain();

    foreach (reach_set[k]) begin
      apb_write(reach_set[k]);
      for (int r = 0; r < 25; r++) begin
        if ($urandom_range(0, 9) == 0) pending_reqs.push_back(answer_req(1'($urandom_range(0, 1))));
        else queue_ray(reach_set[k] > 16'd4096 ? 3 : 8);
      end
      drain();
    end
    apb_write(16'($urandom));
    drain();

    stim_done = 1'b1;
    $display("covered %0d queries, %0d hits, %0d misses, %0d idle answers",
             n_queries, n_hits, n_misses, n_unexp);
    $display("reach settings 0, max, default and two middle values; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== voxel_ray_dda_stepper.f =====
sv/vrd_pkg.sv
sv/vrd_if.sv
sv/vrd_div.sv
sv/vrd_ctrl.sv
sv/vrd_dp.sv
sv/voxel_ray_dda_stepper.sv
sv/vrd_checker.sv
tb/tb_voxel_ray_dda_stepper.sv
